>>> rtl/rvp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the radial vignette pixel block.
// Used by rvp_isqrt, rvp_div and radial_vignette_pixel.
package rvp_pkg;

    // Default coordinate width; frame sizes are one bit wider
    localparam int COORD_BITS_DEF = 12;

    // Fixed-point layout: root has 8 fraction bits on doubled coordinates,
    // so full scale is 512*h; the Q0.16 quotient is (num*128)/h
    localparam int FULL_SHIFT = 9;
    localparam int NUM_SHIFT  = 7;
    localparam int SCALE_BITS = 16;
    localparam int RAD_SHIFT  = 16;

    // Register reset values
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Control that travels alongside the divider pipeline
    typedef struct packed {
        logic vld;
        logic zero;
        logic sat;
    } t_div_ctl;

endpackage

>>> rtl/rvp_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Depends on rvp_pkg for the color side payload type.
module rvp_isqrt #(
    parameter int RB = 22
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [2*RB-1:0]     i_rad,
    input  rvp_pkg::t_rgb       i_rgb,
    output logic                o_valid,
    output logic [RB-1:0]       o_root,
    output rvp_pkg::t_rgb       o_rgb
);

    logic              w_vld  [0:RB];
    logic [RB-1:0]     w_root [0:RB];
    rvp_pkg::t_rgb     w_rgb  [0:RB];
    logic [2*RB-1:0]   w_rad  [0:RB-1];
    logic [RB+1:0]     w_rem  [0:RB-1];

    assign w_vld[0]  = i_valid;
    assign w_root[0] = '0;
    assign w_rgb[0]  = i_rgb;
    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;

    for (genvar g = 0; g < RB; g++) begin : g_stage
        logic [RB+1:0] rem_sh;
        logic [RB+1:0] trial;
        logic          take;
        logic          r_vld;
        logic [RB-1:0] r_root;
        rvp_pkg::t_rgb r_rgb;

        // Bring down two radicand bits and try the next root bit
        always_comb begin
            rem_sh = {w_rem[g][RB-1:0], w_rad[g][2*RB-1:2*RB-2]};
            trial  = {w_root[g], 2'b01};
            take   = (rem_sh >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_root <= {w_root[g][RB-2:0], take};
            r_rgb  <= w_rgb[g];
        end

        assign w_vld[g+1]  = r_vld;
        assign w_root[g+1] = r_root;
        assign w_rgb[g+1]  = r_rgb;

        // Remainder and radicand are needed only ahead of the last stage
        if (g < RB - 1) begin : g_carry
            logic [2*RB-1:0] r_rad;
            logic [RB+1:0]   r_rem;
            always_ff @(posedge i_clk) begin
                r_rad <= {w_rad[g][2*RB-3:0], 2'b00};
                r_rem <= take ? (rem_sh - trial) : rem_sh;
            end
            assign w_rad[g+1] = r_rad;
            assign w_rem[g+1] = r_rem;
        end
    end

    assign o_valid = w_vld[RB];
    assign o_root  = w_root[RB];
    assign o_rgb   = w_rgb[RB];

endmodule

>>> rtl/rvp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, Q0.16 result.
// Depends on rvp_pkg for fixed-point constants and side payload types.
module rvp_div #(
    parameter int DB = 13,
    parameter int NB = DB + rvp_pkg::FULL_SHIFT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rvp_pkg::t_div_ctl                i_ctl,
    input  logic [NB-1:0]                    i_num,
    input  logic [DB-1:0]                    i_den,
    input  rvp_pkg::t_rgb                    i_rgb,
    output rvp_pkg::t_div_ctl                o_ctl,
    output logic [rvp_pkg::SCALE_BITS-1:0]   o_quo,
    output rvp_pkg::t_rgb                    o_rgb
);

    localparam int QB = rvp_pkg::SCALE_BITS;
    localparam int FS = rvp_pkg::FULL_SHIFT;
    localparam int NS = rvp_pkg::NUM_SHIFT;

    rvp_pkg::t_div_ctl w_ctl [0:QB];
    logic [QB-1:0]     w_quo [0:QB];
    rvp_pkg::t_rgb     w_rgb [0:QB];
    logic [DB-1:0]     w_rem [0:QB-1];
    logic [QB-1:0]     w_lo  [0:QB-1];

    // Dividend is num << 7; its top part num >> 9 seeds the remainder
    assign w_ctl[0] = i_ctl;
    assign w_quo[0] = '0;
    assign w_rgb[0] = i_rgb;
    assign w_rem[0] = i_num[NB-1:FS];
    assign w_lo[0]  = {i_num[FS-1:0], {NS{1'b0}}};

    for (genvar g = 0; g < QB; g++) begin : g_stage
        logic [DB:0]       rem_sh;
        logic              take;
        rvp_pkg::t_div_ctl r_ctl;
        logic [QB-1:0]     r_quo;
        rvp_pkg::t_rgb     r_rgb;

        // Shift in the next dividend bit and try a subtract
        always_comb begin
            rem_sh = {w_rem[g], w_lo[g][QB-1]};
            take   = (rem_sh >= {1'b0, i_den});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else begin
                r_ctl <= w_ctl[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_quo <= {w_quo[g][QB-2:0], take};
            r_rgb <= w_rgb[g];
        end

        assign w_ctl[g+1] = r_ctl;
        assign w_quo[g+1] = r_quo;
        assign w_rgb[g+1] = r_rgb;

        if (g < QB - 1) begin : g_carry
            logic [DB-1:0] r_rem;
            logic [QB-1:0] r_lo;
            logic [DB:0]   diff;
            assign diff = rem_sh - {1'b0, i_den};
            always_ff @(posedge i_clk) begin
                r_rem <= take ? diff[DB-1:0] : rem_sh[DB-1:0];
                r_lo  <= {w_lo[g][QB-2:0], 1'b0};
            end
            assign w_rem[g+1] = r_rem;
            assign w_lo[g+1]  = r_lo;
        end
    end

    assign o_ctl = w_ctl[QB];
    assign o_quo = w_quo[QB];
    assign o_rgb = w_rgb[QB];

endmodule

>>> rtl/radial_vignette_pixel.sv
`timescale 1ns / 1ps
// Top level of the radial vignette pixel block.
// Depends on rvp_pkg, rvp_isqrt and rvp_div.
//
// Usage:
//   Pixels enter on i_pix with start; a beat is taken at every clock edge
//   where start is high and busy is low. busy is always low: the pipeline
//   takes one pixel per clock, with no gaps needed between beats.
//   The attenuated pixel appears on o_pix with o_done high for exactly one
//   cycle, in the order the pixels entered. Each pixel passes through the
//   square root, one result bit per stage (COORD_BITS + 10 stages), and the
//   divider, one quotient bit per stage (16 stages), plus five stages of
//   distance, scale and multiply logic.
//   The receiver cannot stall; it must take every result as it appears.
//   Frame width and height are written through i_cfg_we, i_cfg_addr and
//   i_cfg_data while no pixel is in flight; they take effect at once.
//   Synchronous reset clears every valid bit in the pipeline, so no result
//   comes out of pixels taken before reset, and sets the frame to 640x480.
module radial_vignette_pixel #(
    parameter int P_COORD_BITS = rvp_pkg::COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rvp_pkg::t_pix_in     i_pix,
    output logic                 o_done,
    output rvp_pkg::t_pix_out    o_pix,
    input  logic                 i_cfg_we,
    input  rvp_pkg::t_reg_idx    i_cfg_addr,
    input  logic [P_COORD_BITS:0] i_cfg_data
);

    localparam int CB  = P_COORD_BITS;
    localparam int SZ  = CB + 1;
    localparam int RB  = SZ + rvp_pkg::FULL_SHIFT;
    localparam int SB  = rvp_pkg::SCALE_BITS;
    localparam int LAT = RB + 21;

    logic [SZ-1:0] r_width;
    logic [SZ-1:0] r_height;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SZ'(rvp_pkg::WIDTH_RST);
            r_height <= SZ'(rvp_pkg::HEIGHT_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rvp_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                rvp_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic          accept;
    logic [CB-1:0] col;
    logic [CB-1:0] row;
    logic [SZ-1:0] x2;
    logic [SZ-1:0] y2;
    logic [SZ-1:0] n_dx;
    logic [SZ-1:0] n_dy;

    assign accept = start && !busy;

    // Stage 1: doubled coordinates minus frame size, absolute value
    always_comb begin
        col  = CB'(i_pix.pixel_column);
        row  = CB'(i_pix.pixel_row);
        x2   = {col, 1'b0};
        y2   = {row, 1'b0};
        n_dx = (x2 >= r_width)  ? (x2 - r_width)  : (r_width - x2);
        n_dy = (y2 >= r_height) ? (y2 - r_height) : (r_height - y2);
    end

    logic          r_v1;
    logic [SZ-1:0] r_dx;
    logic [SZ-1:0] r_dy;
    rvp_pkg::t_rgb r_rgb1;
    logic          r_v2;
    logic [2*SZ-1:0] r_dx2;
    logic [2*SZ-1:0] r_dy2;
    rvp_pkg::t_rgb r_rgb2;
    logic          r_v3;
    logic [2*RB-1:0] r_rad;
    rvp_pkg::t_rgb r_rgb3;
    logic [2*SZ:0] d2;

    assign d2 = {1'b0, r_dx2} + {1'b0, r_dy2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stages 1 to 3: distances, squares, radicand scaled by 2^16
    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_rgb1 <= '{red: i_pix.red_in, green: i_pix.green_in, blue: i_pix.blue_in};
        r_dx2  <= r_dx * r_dx;
        r_dy2  <= r_dy * r_dy;
        r_rgb2 <= r_rgb1;
        r_rad  <= (2*RB)'({d2, {rvp_pkg::RAD_SHIFT{1'b0}}});
        r_rgb3 <= r_rgb2;
    end

    logic          sq_vld;
    logic [RB-1:0] sq_root;
    rvp_pkg::t_rgb sq_rgb;

    rvp_isqrt #(
        .RB (RB)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .i_rad   (r_rad),
        .i_rgb   (r_rgb3),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_rgb   (sq_rgb)
    );

    // Numerator stage: 512*h minus root, flag clamp cases
    logic [RB-1:0]     full;
    rvp_pkg::t_div_ctl r_nctl;
    logic [RB-1:0]     r_num;
    rvp_pkg::t_rgb     r_nrgb;

    assign full = {r_height, {rvp_pkg::FULL_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nctl <= '0;
        end else begin
            r_nctl.vld  <= sq_vld;
            r_nctl.zero <= (sq_root >= full);
            r_nctl.sat  <= (sq_root == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= full - sq_root;
        r_nrgb <= sq_rgb;
    end

    rvp_pkg::t_div_ctl dv_ctl;
    logic [SB-1:0]     dv_quo;
    rvp_pkg::t_rgb     dv_rgb;

    rvp_div #(
        .DB (SZ),
        .NB (RB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_nctl),
        .i_num   (r_num),
        .i_den   (r_height),
        .i_rgb   (r_nrgb),
        .o_ctl   (dv_ctl),
        .o_quo   (dv_quo),
        .o_rgb   (dv_rgb)
    );

    // Output stage: clamp scale, multiply each channel, round half up
    logic [SB-1:0] scale;
    logic [23:0]   n_red;
    logic [23:0]   n_green;
    logic [23:0]   n_blue;
    logic          r_done;
    rvp_pkg::t_pix_out r_pix;

    always_comb begin
        if (dv_ctl.zero) begin
            scale = '0;
        end else if (dv_ctl.sat) begin
            scale = '1;
        end else begin
            scale = dv_quo;
        end
        n_red   = dv_rgb.red   * scale + 24'h008000;
        n_green = dv_rgb.green * scale + 24'h008000;
        n_blue  = dv_rgb.blue  * scale + 24'h008000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dv_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix.red_out   <= n_red[23:16];
        r_pix.green_out <= n_green[23:16];
        r_pix.blue_out  <= n_blue[23:16];
    end

    assign o_done = r_done;
    assign o_pix  = r_pix;

`ifndef NO_ASSERTIONS
    // Every result beat comes from exactly one taken pixel, a fixed latency back
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done == $past(accept, LAT))
        else $error("result strobe does not match pipeline latency");

    // Reset flushes the pipeline
    a_flush : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

    // A black channel stays black under any scale
    a_black : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(accept && i_pix.red_in == 8'd0, LAT) |-> o_pix.red_out == 8'd0)
        else $error("black red channel came out nonzero");

    // Zero height clamps the scale to zero
    a_zero_h : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nctl.vld && $past(r_height == '0) |-> r_nctl.zero)
        else $error("zero height did not clamp scale");
`endif

endmodule

>>> dv/rvp_checker.sv
`timescale 1ns / 1ps
// Checker for the radial vignette pixel block: mirrors the frame registers,
// predicts each attenuated pixel and compares it with o_pix. Depends on rvp_pkg.
module rvp_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  rvp_pkg::t_pix_in  i_pix,
    input  logic              i_done,
    input  rvp_pkg::t_pix_out i_res,
    input  logic              i_cfg_we,
    input  rvp_pkg::t_reg_idx i_cfg_addr,
    input  logic [12:0]       i_cfg_data,
    output int                o_errors,
    output int                o_pending
);

    logic [12:0]       frame_w;
    logic [12:0]       frame_h;
    rvp_pkg::t_pix_out expected_pix[$];

    assign o_pending = expected_pix.size();

    // Bitwise integer square root
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned b;
        rem = x;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Q0.16 attenuation from the distance to the frame center
    function automatic longint unsigned vignette_scale(input rvp_pkg::t_pix_in p);
        longint unsigned w, h, dx, dy, root, full, s;
        w = frame_w;
        h = frame_h;
        if (h == 0) return 0;
        dx = (2 * p.pixel_column >= w) ? 2 * p.pixel_column - w : w - 2 * p.pixel_column;
        dy = (2 * p.pixel_row >= h) ? 2 * p.pixel_row - h : h - 2 * p.pixel_row;
        root = int_sqrt((dx * dx + dy * dy) << 16);
        full = 512 * h;
        if (root >= full) return 0;
        s = ((full - root) * 128) / h;
        return (s > 65535) ? 65535 : s;
    endfunction

    function automatic logic [7:0] attenuate(input logic [7:0] c,
                                             input longint unsigned s);
        longint unsigned t;
        t = (c * s + 32768) >> 16;
        return t[7:0];
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        longint unsigned s;
        rvp_pkg::t_pix_out e;
        if (!i_rst_n) begin
            frame_w <= 13'(rvp_pkg::WIDTH_RST);
            frame_h <= 13'(rvp_pkg::HEIGHT_RST);
            expected_pix.delete();
        end else begin
            // Check the result beat against the oldest prediction
            if (i_done) begin
                if (expected_pix.size() == 0) begin
                    report("result with no pixel outstanding");
                end else begin
                    e = expected_pix.pop_front();
                    if (i_res.red_out !== e.red_out)
                        report($sformatf("red %0d exp %0d", i_res.red_out, e.red_out));
                    if (i_res.green_out !== e.green_out)
                        report($sformatf("green %0d exp %0d", i_res.green_out, e.green_out));
                    if (i_res.blue_out !== e.blue_out)
                        report($sformatf("blue %0d exp %0d", i_res.blue_out, e.blue_out));
                end
            end
            // Predict on each accepted input beat
            if (i_start && !i_busy) begin
                s = vignette_scale(i_pix);
                e.red_out = attenuate(i_pix.red_in, s);
                e.green_out = attenuate(i_pix.green_in, s);
                e.blue_out = attenuate(i_pix.blue_in, s);
                expected_pix.push_back(e);
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == rvp_pkg::REG_WIDTH) frame_w <= i_cfg_data;
                else frame_h <= i_cfg_data;
            end
        end
    end
endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Stimulus top for the radial vignette pixel block: directed and random pixels
// over several frame sizes. Depends on rvp_pkg, the RTL and rvp_checker.
module tb;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    rvp_pkg::t_pix_in  pix;
    logic              done;
    rvp_pkg::t_pix_out res;
    logic              cfg_we;
    rvp_pkg::t_reg_idx cfg_addr;
    logic [12:0]       cfg_data;
    int                errors;
    int                pending;

    radial_vignette_pixel u_top (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy), .i_pix(pix),
        .o_done(done), .o_pix(res), .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr),
        .i_cfg_data(cfg_data)
    );

    rvp_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy), .i_pix(pix),
        .i_done(done), .i_res(res), .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Hold one beat until accepted, with random idle bursts before it
    task automatic send_pixel(input rvp_pkg::t_pix_in p, input bit idle_ok);
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        pix <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Drain the pipeline, then write one register
    task automatic write_reg(input rvp_pkg::t_reg_idx idx, input logic [12:0] val);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic rvp_pkg::t_pix_in rand_pixel(input int w, input int h);
        rvp_pkg::t_pix_in p;
        p = rvp_pkg::t_pix_in'(48'({$urandom, $urandom}));
        // Mostly in-frame coordinates, sometimes anything
        if ($urandom_range(0, 3) != 0) begin
            p.pixel_column = 12'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
            p.pixel_row = 12'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
        end
        return p;
    endfunction

    int sizes_w[7] = '{640, 1, 4096, 8191, 0, 37, 4096};
    int sizes_h[7] = '{480, 1, 4096, 8191, 17, 0, 64};

    initial begin
        rvp_pkg::t_pix_in p;
        start = 0;
        pix = '0;
        cfg_we = 0;
        cfg_addr = rvp_pkg::REG_WIDTH;
        cfg_data = '0;
        rst_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: center, corners, channel extremes at reset size
        p = '{12'd320, 12'd240, 8'd255, 8'd0, 8'd128};
        send_pixel(p, 0);
        p = '{12'd0, 12'd0, 8'd255, 8'd255, 8'd255};
        send_pixel(p, 0);
        p = '{12'd639, 12'd479, 8'd1, 8'd127, 8'd254};
        send_pixel(p, 0);
        p = '{12'hFFF, 12'hFFF, 8'd255, 8'd255, 8'd255};
        send_pixel(p, 0);
        p = '{12'd0, 12'd240, 8'd200, 8'd100, 8'd50};
        send_pixel(p, 0);
        // Wide frame, short height: corners clamp to zero
        write_reg(rvp_pkg::REG_WIDTH, 13'd4096);
        write_reg(rvp_pkg::REG_HEIGHT, 13'd16);
        p = '{12'd0, 12'd0, 8'd255, 8'd255, 8'd255};
        send_pixel(p, 0);
        p = '{12'd2048, 12'd8, 8'd255, 8'd255, 8'd255};
        send_pixel(p, 0);
        p = '{12'hFFF, 12'd15, 8'd170, 8'd85, 8'd255};
        send_pixel(p, 0);
        // Height zero
        write_reg(rvp_pkg::REG_HEIGHT, 13'd0);
        p = '{12'd5, 12'd0, 8'd255, 8'd255, 8'd255};
        send_pixel(p, 0);
        // Random across sizes
        for (int k = 0; k < 7; k++) begin
            write_reg(rvp_pkg::REG_WIDTH, 13'(sizes_w[k]));
            write_reg(rvp_pkg::REG_HEIGHT, 13'(sizes_h[k]));
            for (int n = 0; n < 90; n++) send_pixel(rand_pixel(sizes_w[k] == 0 ? 1 : sizes_w[k],
                sizes_h[k] == 0 ? 1 : sizes_h[k]), k < 6);
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0) begin
            $display("[radial_vignette_pixel] OK");
        end else begin
            $display("[radial_vignette_pixel] ERROR");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("[radial_vignette_pixel] ERROR");
        $finish;
    end
endmodule

>>> sim.f
rtl/rvp_pkg.sv
rtl/rvp_isqrt.sv
rtl/rvp_div.sv
rtl/radial_vignette_pixel.sv
dv/rvp_checker.sv
dv/tb.sv
